// File: src/ups_pkg.sv
// Shared types, constants and codes for the path canonicalizer.
`default_nettype none
package ups_pkg;

  localparam int unsigned MAX_PATH = 256;
  localparam int unsigned ADDR_W   = $clog2(MAX_PATH);
  localparam int unsigned LEN_W    = $clog2(MAX_PATH + 1);

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned IDX_W    = 8;
  localparam int unsigned RLEN_W   = 9;
  localparam int unsigned S_DATA_W = 16;
  localparam int unsigned M_DATA_W = 24;

  localparam logic [CHAR_W-1:0] SLASH_CH = 8'h2F;
  localparam logic [CHAR_W-1:0] DOT_CH   = 8'h2E;

  localparam logic REQ_FEED = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [CHAR_W-1:0] char_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LEAD,
    S_CHAR,
    S_CLOSE,
    S_WALK,
    S_TRIM,
    S_TRIM_CHK,
    S_OUT
  } state_e;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    char_t wdata;
    logic  re;
    addr_t raddr;
  } mem_req_t;

  typedef struct packed {
    logic              overflow;
    logic              path_done;
    logic [RLEN_W-1:0] result_length;
    char_t             read_char;
  } result_t;

endpackage
`default_nettype wire

// File: src/unix_path_simplifier.sv
// Top level: canonical Unix path builder with byte stream in and result words out.
// Each word passes through the sequencer states and then the output register: a read word
// goes from S_IDLE to S_OUT; a plain path byte through S_CHAR, the first byte of a path also
// through S_LEAD, plus S_WALK while walking back for "..". The final byte adds the segment
// close and trailing-slash check (S_CLOSE, S_TRIM, S_TRIM_CHK). Words are taken one at a time:
// the next only once S_OUT has handed the result on. Reset clears all control state at once.
`default_nettype none
module unix_path_simplifier (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [ups_pkg::S_DATA_W-1:0]  s_axis_tdata,  // char_in[7:0], read_index[15:8]
  input  wire logic                          s_axis_tlast,
  input  wire logic                          s_axis_tuser,  // req_type
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [ups_pkg::M_DATA_W-1:0]       m_axis_tdata   // read_char[7:0],
                                                            // result_length[16:8],
                                                            // path_done[17], overflow[18]
);

  ups_pkg::mem_req_t mem_req;
  ups_pkg::char_t    mem_rdata;
  ups_pkg::result_t  res;
  ups_pkg::result_t  res_out;
  logic              res_valid;
  logic              res_ready;

  ups_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .req_type_i   (s_axis_tuser),
    .char_in_i    (s_axis_tdata[7:0]),
    .last_i       (s_axis_tlast),
    .read_index_i (s_axis_tdata[15:8]),
    .mem_req_o    (mem_req),
    .mem_rdata_i  (mem_rdata),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res)
  );

  ups_ram #(
    .WIDTH (ups_pkg::CHAR_W),
    .DEPTH (ups_pkg::MAX_PATH)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  ups_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .res_o       (res_out)
  );

  assign m_axis_tdata = {5'b0, res_out.overflow, res_out.path_done,
                         res_out.result_length, res_out.read_char};

endmodule
`default_nettype wire

// File: src/ups_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module ups_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: src/ups_ctrl.sv
// Sequencer: path state registers and read-modify-write control of the buffer.
`default_nettype none
module ups_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic                  req_type_i,
  input  wire ups_pkg::char_t        char_in_i,
  input  wire logic                  last_i,
  input  wire logic [ups_pkg::IDX_W-1:0] read_index_i,
  output ups_pkg::mem_req_t          mem_req_o,
  input  wire ups_pkg::char_t        mem_rdata_i,
  output logic                       res_valid_o,
  input  wire logic                  res_ready_i,
  output ups_pkg::result_t           res_o
);

  ups_pkg::state_e state_q, state_d;
  ups_pkg::len_t   len_q, len_d;
  ups_pkg::len_t   seg_q, seg_d;
  logic            dots_q, dots_d;
  logic            fin_q, fin_d;
  logic            ovf_q, ovf_d;
  logic            close2_q, close2_d;
  logic            is_rd_q, is_rd_d;
  logic            rd_ok_q, rd_ok_d;
  ups_pkg::char_t  c_q, c_d;
  logic            last_q, last_d;

  ups_pkg::len_t   seg_n;
  ups_pkg::len_t   len_max;
  ups_pkg::state_e after_close;

  assign len_max     = ups_pkg::len_t'(ups_pkg::MAX_PATH);
  assign seg_n       = (len_q >= seg_q) ? (len_q - seg_q) : '0;
  assign after_close = close2_q ? ups_pkg::S_TRIM : (last_q ? ups_pkg::S_CLOSE : ups_pkg::S_OUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ups_pkg::S_IDLE;
      len_q    <= '0;
      seg_q    <= '0;
      dots_q   <= 1'b1;
      fin_q    <= 1'b0;
      ovf_q    <= 1'b0;
      close2_q <= 1'b0;
      is_rd_q  <= 1'b0;
      rd_ok_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      len_q    <= len_d;
      seg_q    <= seg_d;
      dots_q   <= dots_d;
      fin_q    <= fin_d;
      ovf_q    <= ovf_d;
      close2_q <= close2_d;
      is_rd_q  <= is_rd_d;
      rd_ok_q  <= rd_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q    <= c_d;
    last_q <= last_d;
  end

  always_comb begin
    ups_pkg::len_t nl;
    state_d   = state_q;
    len_d     = len_q;
    seg_d     = seg_q;
    dots_d    = dots_q;
    fin_d     = fin_q;
    ovf_d     = ovf_q;
    close2_d  = close2_q;
    is_rd_d   = is_rd_q;
    rd_ok_d   = rd_ok_q;
    c_d       = c_q;
    last_d    = last_q;
    mem_req_o = '0;
    nl        = len_q;
    in_ready_o  = (state_q == ups_pkg::S_IDLE);
    res_valid_o = 1'b0;

    case (state_q)
      ups_pkg::S_IDLE: begin
        if (in_valid_i) begin
          is_rd_d = req_type_i;
          if (req_type_i == ups_pkg::REQ_READ) begin
            mem_req_o.re    = 1'b1;
            mem_req_o.raddr = ups_pkg::addr_t'(read_index_i);
            rd_ok_d = (32'(read_index_i) < 32'(len_q));
            state_d = ups_pkg::S_OUT;
          end else begin
            c_d      = char_in_i;
            last_d   = last_i;
            close2_d = 1'b0;
            if (fin_q) begin
              len_d   = '0;
              seg_d   = '0;
              dots_d  = 1'b1;
              fin_d   = 1'b0;
              ovf_d   = 1'b0;
              state_d = ups_pkg::S_LEAD;
            end else if (len_q == '0) begin
              state_d = ups_pkg::S_LEAD;
            end else begin
              state_d = ups_pkg::S_CHAR;
            end
          end
        end
      end

      ups_pkg::S_LEAD: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = '0;
        mem_req_o.wdata = ups_pkg::SLASH_CH;
        len_d   = ups_pkg::len_t'(1);
        seg_d   = ups_pkg::len_t'(1);
        dots_d  = 1'b1;
        state_d = ups_pkg::S_CHAR;
      end

      ups_pkg::S_CHAR, ups_pkg::S_CLOSE: begin
        if (state_q == ups_pkg::S_CHAR && c_q != ups_pkg::SLASH_CH) begin
          if (len_q == len_max) begin
            ovf_d = 1'b1;
          end else begin
            mem_req_o.we    = 1'b1;
            mem_req_o.waddr = ups_pkg::addr_t'(len_q);
            mem_req_o.wdata = c_q;
            len_d = len_q + ups_pkg::len_t'(1);
          end
          dots_d = dots_q & (c_q == ups_pkg::DOT_CH);
          if (last_q) begin
            close2_d = 1'b1;
            state_d  = ups_pkg::S_CLOSE;
          end else begin
            state_d  = ups_pkg::S_OUT;
          end
        end else begin
          // close the current segment
          if (state_q == ups_pkg::S_CLOSE) begin
            close2_d = 1'b1;
          end
          if (seg_n == '0) begin
            nl = len_q;
          end else if (dots_q && seg_n == ups_pkg::len_t'(1)) begin
            nl = seg_q;
          end else if (dots_q && seg_n == ups_pkg::len_t'(2)) begin
            nl = seg_q;
          end else if (len_q == len_max) begin
            ovf_d = 1'b1;
          end else begin
            mem_req_o.we    = 1'b1;
            mem_req_o.waddr = ups_pkg::addr_t'(len_q);
            mem_req_o.wdata = ups_pkg::SLASH_CH;
            nl = len_q + ups_pkg::len_t'(1);
          end
          if (dots_q && seg_n == ups_pkg::len_t'(2) && seg_q > ups_pkg::len_t'(1)) begin
            // parent segment: walk back to the previous slash
            len_d           = seg_q - ups_pkg::len_t'(1);
            mem_req_o.re    = 1'b1;
            mem_req_o.raddr = ups_pkg::addr_t'(seg_q - ups_pkg::len_t'(2));
            state_d         = ups_pkg::S_WALK;
          end else begin
            len_d  = nl;
            seg_d  = nl;
            dots_d = 1'b1;
            if (state_q == ups_pkg::S_CLOSE) begin
              state_d = ups_pkg::S_TRIM;
            end else begin
              state_d = after_close;
              if (last_q) begin
                close2_d = 1'b1;
              end
            end
          end
        end
      end

      ups_pkg::S_WALK: begin
        // read data holds buffer[len_q - 1]
        if (mem_rdata_i == ups_pkg::SLASH_CH || len_q == ups_pkg::len_t'(1)) begin
          nl = (mem_rdata_i == ups_pkg::SLASH_CH) ? len_q : '0;
          len_d   = nl;
          seg_d   = nl;
          dots_d  = 1'b1;
          state_d = after_close;
          if (!close2_q && last_q) begin
            close2_d = 1'b1;
          end
        end else begin
          len_d           = len_q - ups_pkg::len_t'(1);
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = ups_pkg::addr_t'(len_q - ups_pkg::len_t'(2));
        end
      end

      ups_pkg::S_TRIM: begin
        if (len_q > ups_pkg::len_t'(1)) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = ups_pkg::addr_t'(len_q - ups_pkg::len_t'(1));
          state_d         = ups_pkg::S_TRIM_CHK;
        end else begin
          seg_d   = len_q;
          fin_d   = 1'b1;
          state_d = ups_pkg::S_OUT;
        end
      end

      ups_pkg::S_TRIM_CHK: begin
        nl = (mem_rdata_i == ups_pkg::SLASH_CH) ? (len_q - ups_pkg::len_t'(1)) : len_q;
        len_d   = nl;
        seg_d   = nl;
        fin_d   = 1'b1;
        state_d = ups_pkg::S_OUT;
      end

      ups_pkg::S_OUT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ups_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = ups_pkg::S_IDLE;
      end
    endcase
  end

  assign res_o.read_char     = (is_rd_q && rd_ok_q) ? mem_rdata_i : '0;
  assign res_o.result_length = ups_pkg::RLEN_W'(len_q);
  assign res_o.path_done     = fin_q;
  assign res_o.overflow      = ovf_q;

endmodule
`default_nettype wire

// File: src/ups_obuf.sv
// Output register between the sequencer and the result stream.
`default_nettype none
module ups_obuf (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              res_valid_i,
  output logic                   res_ready_o,
  input  wire ups_pkg::result_t  res_i,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output ups_pkg::result_t       res_o
);

  logic             valid_q, valid_d;
  ups_pkg::result_t res_q;

  assign res_ready_o = !valid_q || ready_i;
  assign valid_d     = res_valid_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i && res_ready_o) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule
`default_nettype wire

// File: src/ups_checker.sv
// Port-level checker for the path canonicalizer, bound to the top level.
`default_nettype none
module ups_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         s_axis_tvalid,
  input wire logic                         s_axis_tready,
  input wire logic                         m_axis_tvalid,
  input wire logic                         m_axis_tready,
  input wire logic [ups_pkg::M_DATA_W-1:0] m_axis_tdata
);

  logic [ups_pkg::RLEN_W-1:0] rlen;
  assign rlen = m_axis_tdata[16:8];

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (32'(rlen) <= ups_pkg::MAX_PATH))
    else $error("result length beyond buffer size");

  a_done_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[17]) |-> (rlen != '0))
    else $error("finished path is empty");

  a_char_needs_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[7:0] != 8'h00) |-> (rlen != '0))
    else $error("byte returned from empty path");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result word changed");

  a_ready_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken again before the word was processed");

endmodule

bind unix_path_simplifier ups_checker u_ups_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

// File: tb/unix_path_simplifier_checker.sv
// Checker for the path canonicalizer: tracks the canonical path and compares every result word.
`timescale 1ns / 1ps
module unix_path_simplifier_checker
  import ups_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [S_DATA_W-1:0] s_axis_tdata,   // char_in[7:0], read_index[15:8]
  input  logic                s_axis_tlast,
  input  logic                s_axis_tuser,   // req_type
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [M_DATA_W-1:0] m_axis_tdata,   // read_char, result_length, path_done, overflow
  output int unsigned         fail_count_o,
  output int unsigned         pending_o,
  output int unsigned         checked_o
);

  localparam int unsigned RES_W = $bits(result_t);

  char_t       path_mem [MAX_PATH];
  int unsigned path_len  = 0;
  int unsigned seg_base  = 0;
  bit          seg_dots  = 1'b1;
  bit          done_flag = 1'b0;
  bit          ovf_flag  = 1'b0;

  result_t     path_result_q [$];
  int unsigned fails   = 0;
  int unsigned checked = 0;

  function automatic void store_char(char_t c);
    if (path_len >= MAX_PATH) begin
      ovf_flag = 1'b1;
    end else begin
      path_mem[path_len] = c;
      path_len++;
    end
  endfunction

  function automatic void close_seg();
    int unsigned seg_len;
    seg_len = (path_len >= seg_base) ? path_len - seg_base : 0;
    if (seg_len == 0) begin
      // repeated slash
    end else if (seg_dots && seg_len == 1) begin
      path_len = seg_base;
    end else if (seg_dots && seg_len == 2) begin
      // parent dir: back up past the previous slash, stop at root
      path_len = seg_base;
      if (path_len > 1) begin
        path_len--;
        while (path_len > 0 && path_mem[path_len-1] != SLASH_CH) path_len--;
      end
    end else begin
      store_char(SLASH_CH);
    end
    seg_base = path_len;
    seg_dots = 1'b1;
  endfunction

  function automatic result_t canon_word(logic req, char_t ch, logic lst,
                                         logic [IDX_W-1:0] idx);
    result_t r;
    r = '0;
    if (req == REQ_FEED) begin
      if (done_flag) begin
        path_len  = 0;
        seg_base  = 0;
        seg_dots  = 1'b1;
        done_flag = 1'b0;
        ovf_flag  = 1'b0;
      end
      if (path_len == 0) begin
        store_char(SLASH_CH);
        seg_base = path_len;
        seg_dots = 1'b1;
      end
      if (ch == SLASH_CH) begin
        close_seg();
      end else begin
        store_char(ch);
        if (ch != DOT_CH) seg_dots = 1'b0;
      end
      if (lst) begin
        close_seg();
        if (path_len > 1 && path_mem[path_len-1] == SLASH_CH) path_len--;
        seg_base  = path_len;
        done_flag = 1'b1;
      end
    end else if (idx < path_len) begin
      r.read_char = path_mem[idx];
    end
    r.result_length = RLEN_W'(path_len);
    r.path_done     = done_flag;
    r.overflow      = ovf_flag;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] have);
    if (have !== want) begin
      fails++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, have);
    end
  endtask

  always @(posedge clk_i) begin
    result_t want;
    result_t have;
    if (!rst_ni) begin
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        path_result_q.push_back(canon_word(s_axis_tuser, s_axis_tdata[7:0], s_axis_tlast,
                                           s_axis_tdata[15:8]));
      if (m_axis_tvalid && m_axis_tready) begin
        if (path_result_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result word, expected none actual %0h",
                   $time, m_axis_tdata);
        end else begin
          want = path_result_q.pop_front();
          have = m_axis_tdata[RES_W-1:0];
          checked++;
          check_field("read_char", 16'(want.read_char), 16'(have.read_char));
          check_field("result_length", 16'(want.result_length), 16'(have.result_length));
          check_field("path_done", 16'(want.path_done), 16'(have.path_done));
          check_field("overflow", 16'(want.overflow), 16'(have.overflow));
          check_field("tdata pad", 16'(0), 16'(m_axis_tdata[M_DATA_W-1:RES_W]));
        end
      end
      fail_count_o <= fails;
      pending_o    <= path_result_q.size();
      checked_o    <= checked;
    end
  end

endmodule

// File: tb/unix_path_simplifier_tb.sv
// Testbench top for the path canonicalizer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module unix_path_simplifier_tb;
  import ups_pkg::*;

  localparam int unsigned    TOTAL_WORDS  = 1850;
  localparam longint unsigned CYCLE_LIMIT = 5_000_000;
  localparam int unsigned    DRAIN_CYCLES = 300;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata  = '0;
  logic                s_axis_tlast  = 1'b0;
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;

  int unsigned     fail_count;
  int unsigned     pending;
  int unsigned     checked;
  longint unsigned cycles = 0;
  int unsigned     n_words = 0;
  int unsigned     n_reads = 0;
  int unsigned     n_bytes = 0;
  int unsigned     n_paths = 0;
  int unsigned     read_mix = 0;
  int unsigned     rx_left = 0;

  unix_path_simplifier DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  unix_path_simplifier_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // sink side: calm windows with tready held high, random stalls otherwise
  always @(posedge clk_i) begin
    if (((cycles >> 9) % 4) == 0) begin
      m_axis_tready <= 1'b1;
    end else if (rx_left != 0) begin
      rx_left--;
    end else if ($urandom_range(0, 1) == 1) begin
      m_axis_tready <= 1'b1;
      rx_left = $urandom_range(0, 7);
    end else begin
      m_axis_tready <= 1'b0;
      rx_left = idle_len() + 1;
    end
  end

  task automatic send_word(input logic req, input char_t ch, input logic lst,
                           input logic [IDX_W-1:0] idx);
    int unsigned gap;
    gap = (((n_words >> 7) % 4) == 1) ? 0 : idle_len();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {idx, ch};
    s_axis_tlast  <= lst;
    s_axis_tuser  <= req;
    do @(posedge clk_i); while (!s_axis_tready);
    n_words++;
    if (req == REQ_READ) begin
      n_reads++;
    end else begin
      n_bytes++;
      if (lst) n_paths++;
    end
  endtask

  task automatic send_read(input logic [IDX_W-1:0] idx);
    send_word(REQ_READ, char_t'($urandom), 1'($urandom), idx);
  endtask

  function automatic logic [IDX_W-1:0] pick_index();
    if ($urandom_range(0, 9) < 7) return IDX_W'($urandom_range(0, 24));
    return IDX_W'($urandom_range(0, 255));
  endfunction

  task automatic feed_path(input char_t q[$], input bit mark_last);
    for (int i = 0; i < q.size(); i++) begin
      if ($urandom_range(0, 99) < read_mix) send_read(pick_index());
      send_word(REQ_FEED, q[i], mark_last && (i == q.size() - 1), IDX_W'($urandom));
    end
  endtask

  function automatic void add_text(ref char_t q[$], input string s);
    for (int i = 0; i < s.len(); i++) q.push_back(char_t'(s[i]));
  endfunction

  function automatic char_t name_char();
    int unsigned r;
    char_t c;
    r = $urandom_range(0, 99);
    if (r < 75) return char_t'(8'h61 + $urandom_range(0, 25));
    if (r < 88) return DOT_CH;
    do c = char_t'($urandom); while (c == SLASH_CH);
    return c;
  endfunction

  function automatic void add_segment(ref char_t q[$]);
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      q.push_back(DOT_CH);
    end else if (r < 35) begin
      q.push_back(DOT_CH);
      q.push_back(DOT_CH);
    end else if (r < 40) begin
      repeat (3) q.push_back(DOT_CH);
    end else if (r < 45) begin
      q.push_back(DOT_CH);
      q.push_back(name_char());
    end else begin
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
      repeat (n) q.push_back(name_char());
    end
    r = $urandom_range(0, 99);
    n = (r < 75) ? 1 : (r < 92) ? 2 : 3;
    repeat (n) q.push_back(SLASH_CH);
  endfunction

  function automatic void build_path(ref char_t q[$], input int unsigned min_len);
    int unsigned nseg;
    q = {};
    if ($urandom_range(0, 9) != 0) q.push_back(SLASH_CH);
    nseg = $urandom_range(0, 8);
    for (int i = 0; i < nseg || q.size() < min_len; i++) add_segment(q);
    if ($urandom_range(0, 1) == 1)
      while (q.size() > 1 && q[q.size()-1] == SLASH_CH) void'(q.pop_back());
    if (q.size() == 0) q.push_back(SLASH_CH);
  endfunction

  initial begin
    char_t       q [$];
    int unsigned r;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // overflowing path first: every buffer entry is written before any read
    q = {SLASH_CH};
    repeat (300) q.push_back(char_t'(8'h61));
    feed_path(q, 1'b1);
    send_read(8'd255);
    send_read(8'd0);
    send_read(8'd128);

    // long parent-dir walk back to root
    q = {SLASH_CH};
    repeat (250) q.push_back(char_t'(8'h62));
    add_text(q, "/..");
    feed_path(q, 1'b1);
    send_read(8'd0);

    // single marked byte, slash and name
    q = {SLASH_CH};
    feed_path(q, 1'b1);
    q = {char_t'(8'h78)};
    feed_path(q, 1'b1);
    send_read(8'd1);

    q = {};
    add_text(q, "//a//./b/../../..//c/");
    feed_path(q, 1'b1);
    q = {};
    add_text(q, "/.../.x/..");
    feed_path(q, 1'b1);
    send_read(8'd3);
    q = {};
    add_text(q, "a/..");
    feed_path(q, 1'b1);
    q = {SLASH_CH, char_t'(8'h00), SLASH_CH, char_t'(8'hFF)};
    feed_path(q, 1'b1);
    send_read(8'd1);
    send_read(8'd3);

    // reads in the middle of a path
    q = {};
    add_text(q, "/ab");
    feed_path(q, 1'b0);
    send_read(8'd2);
    send_read(8'd9);
    q = {};
    add_text(q, "/../c");
    feed_path(q, 1'b1);

    while (n_words < TOTAL_WORDS) begin
      r = $urandom_range(0, 99);
      if (r < 1) begin
        read_mix = 3;
        build_path(q, $urandom_range(257, 400));
        feed_path(q, 1'b1);
      end else if (r < 78) begin
        read_mix = $urandom_range(0, 30);
        build_path(q, 0);
        feed_path(q, 1'b1);
        repeat ($urandom_range(0, 4)) send_read(pick_index());
      end else if (r < 89) begin
        repeat ($urandom_range(1, 6)) send_read(pick_index());
      end else begin
        repeat ($urandom_range(1, 8))
          send_word(REQ_FEED, char_t'($urandom), ($urandom_range(0, 4) == 0),
                    IDX_W'($urandom));
      end
    end
    s_axis_tvalid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d words: %0d path bytes, %0d reads, %0d finished paths",
             n_words, n_bytes, n_reads, n_paths);
    $display("Compared %0d result words, %0d field mismatches", checked, fail_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
src/ups_pkg.sv
src/ups_ram.sv
src/ups_ctrl.sv
src/ups_obuf.sv
src/unix_path_simplifier.sv
src/ups_checker.sv
tb/unix_path_simplifier_checker.sv
tb/unix_path_simplifier_tb.sv
